>>> hw/rtl/mbet_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mbet_pkg: shared types, constants and helpers for the escape-time evaluator
// Payload structs, configuration register codes, Q4.28 saturation and the
// colour map used by the pixel datapath and the top level.
// ============================================================================
package mbet_pkg;

    // fixed field widths
    localparam int PIX_W   = 11;
    localparam int Q_W     = 32;
    localparam int STEP_W  = 31;
    localparam int ITER_W  = 8;
    localparam int CHAN_W  = 8;
    localparam int PROD_W  = 2 * Q_W;
    localparam int SAT_W   = 45;
    localparam int REG_IDX_W = 3;
    localparam int CFG_W   = 32;

    localparam int MAX_DIM_DEF = 2048;

    // configuration reset values
    localparam logic signed [Q_W-1:0]  ORIGIN_REAL_RST = 32'shE000_0000;
    localparam logic signed [Q_W-1:0]  ORIGIN_IMAG_RST = 32'shF000_0000;
    localparam logic [STEP_W-1:0]      STEP_REAL_RST   = 31'd262144;
    localparam logic [STEP_W-1:0]      STEP_IMAG_RST   = 31'd262144;
    localparam logic [ITER_W-1:0]      ITER_LIMIT_RST  = 8'd255;

    // escape threshold: |z|^2 >= 4 in Q8.56
    localparam logic [PROD_W-1:0] ESCAPE_Q56 = 64'd4 << 56;

    // colour bases
    localparam logic [CHAN_W-1:0] RED_BASE   = 8'd238;
    localparam logic [CHAN_W-1:0] GREEN_BASE = 8'd130;
    localparam logic [CHAN_W-1:0] BLUE_BASE  = 8'd238;

    // saturation bounds at the wide add width
    localparam logic signed [SAT_W-1:0] SAT_MAX =
        {{(SAT_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
    localparam logic signed [SAT_W-1:0] SAT_MIN =
        {{(SAT_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};

    // configuration register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_ORIGIN_REAL = 3'd0,
        REG_ORIGIN_IMAG = 3'd1,
        REG_STEP_REAL   = 3'd2,
        REG_STEP_IMAG   = 3'd3,
        REG_ITER_LIMIT  = 3'd4
    } mbet_reg_idx_t;

    typedef struct packed {
        logic signed [Q_W-1:0] origin_real;
        logic signed [Q_W-1:0] origin_imag;
        logic [STEP_W-1:0]     step_real;
        logic [STEP_W-1:0]     step_imag;
        logic [ITER_W-1:0]     iteration_limit;
    } mbet_cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_column;
        logic [PIX_W-1:0] pixel_row;
    } pixel_t;

    typedef struct packed {
        logic              escaped;
        logic [ITER_W-1:0] escape_iteration;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } result_t;

    // clip a wide signed value to the Q4.28 range
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[Q_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[Q_W-1:0];
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    // base minus iteration, floored at zero
    function automatic logic [CHAN_W-1:0] chan_sub(input logic [CHAN_W-1:0] base,
                                                   input logic [ITER_W-1:0] n);
        logic [CHAN_W-1:0] r;
        if (n < base) begin
            r = base - n;
        end else begin
            r = '0;
        end
        return r;
    endfunction

    // pack a finished pixel, black when it never escaped
    function automatic result_t make_result(input logic hit, input logic [ITER_W-1:0] n);
        result_t r;
        r = '0;
        if (hit) begin
            r.escaped          = 1'b1;
            r.escape_iteration = n;
            r.red              = chan_sub(RED_BASE, n);
            r.green            = chan_sub(GREEN_BASE, n);
            r.blue             = chan_sub(BLUE_BASE, n);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/mandelbrot_escape_time_pixel.sv
`timescale 1ns / 1ps
// Each accepted pixel is mapped to c and then iterated until it escapes or its
// iteration count reaches the limit. Only one pixel is in work at a time, input
// not ready meanwhile; the shared multiplier is used three times per iteration.
// A finished result sits in the output register while the next pixel is taken.
// Reset (aresetn low, synchronous) clears sequencer and output valid, restores config.
// ============================================================================
// mandelbrot_escape_time_pixel: escape-time evaluator for one pixel
// Holds the configuration registers and wraps the iterative datapath that
// maps a pixel to c, iterates z = z*z + c and colours the escape count.
// ============================================================================
module mandelbrot_escape_time_pixel #(
    parameter int MAX_DIM = mbet_pkg::MAX_DIM_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [mbet_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [mbet_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  mbet_pkg::pixel_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output mbet_pkg::result_t                m_data
);
    import mbet_pkg::*;

    logic signed [Q_W-1:0] origin_real_reg;
    logic signed [Q_W-1:0] origin_imag_reg;
    logic [STEP_W-1:0]     step_real_reg;
    logic [STEP_W-1:0]     step_imag_reg;
    logic [ITER_W-1:0]     iter_limit_reg;
    mbet_cfg_t             cfg;

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_real_reg <= ORIGIN_REAL_RST;
            origin_imag_reg <= ORIGIN_IMAG_RST;
            step_real_reg   <= STEP_REAL_RST;
            step_imag_reg   <= STEP_IMAG_RST;
            iter_limit_reg  <= ITER_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ORIGIN_REAL: origin_real_reg <= cfg_wdata;
                REG_ORIGIN_IMAG: origin_imag_reg <= cfg_wdata;
                REG_STEP_REAL:   step_real_reg   <= cfg_wdata[STEP_W-1:0];
                REG_STEP_IMAG:   step_imag_reg   <= cfg_wdata[STEP_W-1:0];
                REG_ITER_LIMIT:  iter_limit_reg  <= cfg_wdata[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.origin_real     = origin_real_reg;
        cfg.origin_imag     = origin_imag_reg;
        cfg.step_real       = step_real_reg;
        cfg.step_imag       = step_imag_reg;
        cfg.iteration_limit = iter_limit_reg;
    end

    // iterative datapath
    mbet_core #(
        .MAX_DIM (MAX_DIM)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> hw/rtl/mbet_core.sv
`timescale 1ns / 1ps
// ============================================================================
// mbet_core: iterative escape-time datapath
// One registered 32x32 signed multiplier shared under a small sequencer maps
// the pixel to c and runs z = z*z + c.
// ============================================================================
module mbet_core #(
    parameter int MAX_DIM = mbet_pkg::MAX_DIM_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mbet_pkg::mbet_cfg_t cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  mbet_pkg::pixel_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mbet_pkg::result_t   m_data
);
    import mbet_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CR_MUL,
        ST_CR_ADD,
        ST_CI_MUL,
        ST_CI_ADD,
        ST_RI,
        ST_Z,
        ST_RR,
        ST_II,
        ST_DONE
    } state_t;

    state_t                    state_reg;
    logic [PIX_W-1:0]          col_reg;
    logic [PIX_W-1:0]          row_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [Q_W-1:0]     cr_reg;
    logic signed [Q_W-1:0]     ci_reg;
    logic signed [Q_W-1:0]     zr_reg;
    logic signed [Q_W-1:0]     zi_reg;
    logic signed [PROD_W-1:0]  rr_reg;
    logic signed [PROD_W-29:0] diff_reg;
    logic [ITER_W-1:0]         n_reg;
    result_t                   res_reg;
    logic                      m_valid_reg;
    result_t                   m_data_reg;

    logic signed [Q_W-1:0]     mul_a;
    logic signed [Q_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]  mul_prod;
    logic signed [Q_W-1:0]     origin_sel;
    logic signed [SAT_W-1:0]   coord_sum;
    logic signed [SAT_W-1:0]   re_sum;
    logic signed [SAT_W-1:0]   im_sum;
    logic signed [PROD_W-1:0]  diff_full;
    logic [PROD_W-1:0]         mag;
    logic [PIX_W-1:0]          col_clamped;
    logic [PIX_W-1:0]          row_clamped;

    // clamp indexes to the viewport size
    always_comb begin
        col_clamped = s_data.pixel_column;
        row_clamped = s_data.pixel_row;
        if (int'(s_data.pixel_column) > MAX_DIM - 1) begin
            col_clamped = PIX_W'(MAX_DIM - 1);
        end
        if (int'(s_data.pixel_row) > MAX_DIM - 1) begin
            row_clamped = PIX_W'(MAX_DIM - 1);
        end
    end

    // shared multiplier operand select, zero when idle so products start clean
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_CR_MUL: begin
                mul_a = {1'b0, cfg.step_real};
                mul_b = Q_W'(col_reg);
            end
            ST_CI_MUL: begin
                mul_a = {1'b0, cfg.step_imag};
                mul_b = Q_W'(row_reg);
            end
            ST_RI: begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
            ST_RR: begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            ST_II: begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default: ;
        endcase
    end

    assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // coordinate add: origin plus step times index
    assign origin_sel = (state_reg == ST_CR_ADD) ? cfg.origin_real : cfg.origin_imag;
    assign coord_sum  = SAT_W'(origin_sel) + SAT_W'(prod_reg[43:0]);

    // zr*zr - zi*zi and the escape magnitude, both from rr_reg and the zi square
    assign diff_full = rr_reg - prod_reg;
    assign mag       = $unsigned(rr_reg) + $unsigned(prod_reg);

    // new z: floor shift back to Q4.28, add c
    assign re_sum = SAT_W'(diff_reg) + SAT_W'(cr_reg);
    assign im_sum = SAT_W'($signed(prod_reg[PROD_W-1:27])) + SAT_W'(ci_reg);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            prod_reg <= mul_prod;
            // output drains unless a new result is loaded in the same cycle
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        col_reg   <= col_clamped;
                        row_reg   <= row_clamped;
                        state_reg <= ST_CR_MUL;
                    end
                end
                ST_CR_MUL: begin
                    state_reg <= ST_CR_ADD;
                end
                ST_CR_ADD: begin
                    cr_reg    <= sat_q(coord_sum);
                    state_reg <= ST_CI_MUL;
                end
                ST_CI_MUL: begin
                    state_reg <= ST_CI_ADD;
                end
                ST_CI_ADD: begin
                    ci_reg    <= sat_q(coord_sum);
                    zr_reg    <= '0;
                    zi_reg    <= '0;
                    rr_reg    <= '0;
                    n_reg     <= '0;
                    state_reg <= ST_RI;
                end
                ST_RI: begin
                    diff_reg <= diff_full[PROD_W-1:28];
                    if (mag >= ESCAPE_Q56) begin
                        res_reg   <= make_result(1'b1, n_reg);
                        state_reg <= ST_DONE;
                    end else if (n_reg == cfg.iteration_limit) begin
                        res_reg   <= make_result(1'b0, n_reg);
                        state_reg <= ST_DONE;
                    end else begin
                        n_reg     <= n_reg + 8'd1;
                        state_reg <= ST_Z;
                    end
                end
                ST_Z: begin
                    zr_reg    <= sat_q(re_sum);
                    zi_reg    <= sat_q(im_sum);
                    state_reg <= ST_RR;
                end
                ST_RR: begin
                    state_reg <= ST_II;
                end
                ST_II: begin
                    rr_reg    <= prod_reg;
                    state_reg <= ST_RI;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // accepted transaction starts the coordinate mapping
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_CR_MUL))
        else $error("accepted pixel did not start mapping");

    // a point that never escaped is reported black with count zero
    a_black_no_escape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.escaped) |-> (m_data.escape_iteration == 8'd0 &&
        m_data.red == 8'd0 && m_data.green == 8'd0 && m_data.blue == 8'd0))
        else $error("non-escaped pixel not black");

    // an escape always happens on a counted iteration
    a_escape_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.escaped) |-> (m_data.escape_iteration != 8'd0))
        else $error("escape reported at iteration zero");

    // iteration counter never passes the limit
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RI) |-> (n_reg <= cfg.iteration_limit))
        else $error("iteration count beyond limit");

    // finished result waits while the output register is still full
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid && !m_ready) |=> (state_reg == ST_DONE))
        else $error("result dropped while output stalled");

endmodule

>>> verif/mandelbrot_escape_time_pixel_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// mandelbrot_escape_time_pixel_tb: self-checking bench for the pixel evaluator
// Directed pixels hit the viewport corners, the iteration limit extremes,
// coordinate saturation and the color floors. A long output hold-off follows
// with random pixels, then random viewports run under three idle mixes. Every
// result is checked field by field against the bench's escape-time predictor.
// ============================================================================
module mandelbrot_escape_time_pixel_tb;
    import mbet_pkg::*;

    localparam int     MAX_DIM     = 2048;
    localparam int     Q_ONE       = 1 << 28;
    localparam longint Q_MAX       = 64'sd2147483647;
    localparam longint Q_MIN       = -64'sd2147483648;
    localparam logic [63:0] ESCAPE_MAG = 64'd4 << 56;
    localparam int     RED_FADE    = 238;
    localparam int     GREEN_FADE  = 130;
    localparam int     BLUE_FADE   = 238;
    localparam int     PHASE_PIXELS = 40;
    // longest quiet stretch: output hold-off plus a full 255-iteration pixel, several times over
    localparam int     STALL_LIMIT = 20000;
    localparam int     HOLD_OFF    = 2500;
    localparam int     TAIL_CYCLES = 1100;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    pixel_t            s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    result_t           m_data;

    // bench copy of the viewport registers
    mbet_cfg_t         viewport;
    result_t           results_due[$];
    int                error_count       = 0;
    int                send_idle_pct     = 0;
    int                recv_idle_pct     = 0;
    int                recv_hold_cycles  = 0;
    int                quiet_cycles      = 0;

    mandelbrot_escape_time_pixel #(.MAX_DIM(MAX_DIM)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // clip to the signed Q4.28 range
    function automatic longint clip_q(longint v);
        if (v > Q_MAX) begin
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            return Q_MIN;
        end
        return v;
    endfunction

    // escape count and color for one pixel under a given viewport
    function automatic result_t escape_time_of(pixel_t px, mbet_cfg_t vp);
        longint      col, row, cr, ci, zr, zi, rr, ii, ri;
        logic [63:0] mag;
        int unsigned hit;
        result_t     res;
        col = longint'(px.pixel_column);
        row = longint'(px.pixel_row);
        if (col >= MAX_DIM) begin
            col = MAX_DIM - 1;
        end
        if (row >= MAX_DIM) begin
            row = MAX_DIM - 1;
        end
        cr  = clip_q(longint'(vp.origin_real) + longint'(vp.step_real) * col);
        ci  = clip_q(longint'(vp.origin_imag) + longint'(vp.step_imag) * row);
        zr  = 0;
        zi  = 0;
        hit = 0;
        // z = z*z + c, products exact at Q8.56, floored back to Q4.28
        for (int n = 1; n <= vp.iteration_limit && hit == 0; n++) begin
            rr  = zr * zr;
            ii  = zi * zi;
            ri  = zr * zi;
            zr  = clip_q(((rr - ii) >>> 28) + cr);
            zi  = clip_q((ri >>> 27) + ci);
            mag = zr * zr + zi * zi;
            if (mag >= ESCAPE_MAG) begin
                hit = n;
            end
        end
        res = '0;
        if (hit != 0) begin
            res.escaped          = 1'b1;
            res.escape_iteration = 8'(hit);
            res.red              = (hit < RED_FADE)   ? 8'(RED_FADE - hit)   : 8'd0;
            res.green            = (hit < GREEN_FADE) ? 8'(GREEN_FADE - hit) : 8'd0;
            res.blue             = (hit < BLUE_FADE)  ? 8'(BLUE_FADE - hit)  : 8'd0;
        end
        return res;
    endfunction

    // first row of column zero whose escape count falls in [lo, hi]
    function automatic int row_escaping_between(int lo, int hi);
        pixel_t  px;
        result_t r;
        px = '0;
        for (int row = 0; row < MAX_DIM; row++) begin
            px.pixel_row = PIX_W'(row);
            r = escape_time_of(px, viewport);
            if (r.escaped && r.escape_iteration >= lo && r.escape_iteration <= hi) begin
                return row;
            end
        end
        return 0;
    endfunction

    // output side: long hold-off on request, else random stalls
    always @(negedge aclk) begin
        if (recv_hold_cycles > 0) begin
            m_ready <= 1'b0;
            recv_hold_cycles = recv_hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            error_count++;
        end
    endtask

    // compare every result transaction with the oldest expectation
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %p", $time, m_data);
                error_count++;
            end else begin
                want = results_due.pop_front();
                check_field("escaped", 8'(want.escaped), 8'(m_data.escaped));
                check_field("escape_iteration", want.escape_iteration,
                            m_data.escape_iteration);
                check_field("red", want.red, m_data.red);
                check_field("green", want.green, m_data.green);
                check_field("blue", want.blue, m_data.blue);
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, results_due.size());
            $display("mandelbrot_escape_time_pixel_tb: errors");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so the caller sends again or releases the input
    task automatic send_pixel(pixel_t px);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (s_ready !== 1'b1);
        results_due.push_back(escape_time_of(px, viewport));
        @(negedge aclk);
    endtask

    task automatic send_at(int col, int row);
        pixel_t px;
        px.pixel_column = PIX_W'(col);
        px.pixel_row    = PIX_W'(row);
        send_pixel(px);
    endtask

    task automatic release_input();
        s_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (results_due.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // register write, only while the evaluator is idle
    task automatic set_register(mbet_reg_idx_t idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_ORIGIN_REAL: viewport.origin_real     = value;
            REG_ORIGIN_IMAG: viewport.origin_imag     = value;
            REG_STEP_REAL:   viewport.step_real       = value[STEP_W-1:0];
            REG_STEP_IMAG:   viewport.step_imag       = value[STEP_W-1:0];
            REG_ITER_LIMIT:  viewport.iteration_limit = value[ITER_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_view(logic [31:0] ore, logic [31:0] oim, logic [31:0] sre,
                            logic [31:0] sim, logic [31:0] lim);
        set_register(REG_ORIGIN_REAL, ore);
        set_register(REG_ORIGIN_IMAG, oim);
        set_register(REG_STEP_REAL, sre);
        set_register(REG_STEP_IMAG, sim);
        set_register(REG_ITER_LIMIT, lim);
    endtask

    // corners and interior points of the reset viewport
    task automatic test_reset_view();
        send_at(0, 0);
        send_at(MAX_DIM - 1, MAX_DIM - 1);
        send_at(MAX_DIM - 1, 0);
        send_at(0, MAX_DIM - 1);
        send_at(1536, 1024);
        send_at(1024, 1024);
        release_input();
        wait_drain();
    endtask

    // limit of zero, one and the maximum
    task automatic test_iteration_limit();
        set_view(0, 0, 0, 0, 0);
        send_at(0, 0);
        send_at(MAX_DIM - 1, MAX_DIM - 1);
        release_input();
        wait_drain();
        set_register(REG_ITER_LIMIT, 1);
        send_at(5, 9);
        release_input();
        wait_drain();
        // c = 2 lands exactly on the escape radius
        set_register(REG_ORIGIN_REAL, 2 * Q_ONE);
        send_at(3, 3);
        release_input();
        wait_drain();
        set_register(REG_ITER_LIMIT, 255);
        send_at(0, 0);
        release_input();
        wait_drain();
        set_register(REG_ORIGIN_REAL, -2 * Q_ONE);
        send_at(0, 0);
        release_input();
        wait_drain();
    endtask

    // origin plus step times index beyond the Q4.28 maximum on both axes, and the most negative origin
    task automatic test_coordinate_saturation();
        set_view(32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 0, 16);
        send_at(0, 0);
        send_at(MAX_DIM - 1, 0);
        release_input();
        wait_drain();
        set_register(REG_ORIGIN_REAL, 32'h8000_0000);
        send_at(0, 0);
        send_at(1, 0);
        send_at(2, 0);
        send_at(3, 0);
        release_input();
        wait_drain();
        set_view(0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 16);
        send_at(0, 0);
        send_at(0, MAX_DIM - 1);
        release_input();
        wait_drain();
    endtask

    // zoom on the neck at -0.75 where escape counts run long, to hit the color floors
    task automatic test_color_floor();
        set_view(-(3 * Q_ONE / 4), Q_ONE / 200, 0, 16384, 255);
        send_at(0, row_escaping_between(238, 255));
        send_at(0, row_escaping_between(130, 237));
        send_at(0, row_escaping_between(1, 129));
        send_at(0, 0);
        release_input();
        wait_drain();
    endtask

    // output held off long enough that the block stalls its input
    task automatic test_receiver_hold_off();
        set_view(-2 * Q_ONE, -Q_ONE, 262144, 262144, 8);
        @(posedge aclk);
        recv_hold_cycles = HOLD_OFF;
        @(negedge aclk);
        repeat (8) send_at($urandom_range(MAX_DIM - 1), $urandom_range(MAX_DIM - 1));
        release_input();
        wait_drain();
    endtask

    // mostly the interesting region with short limits, some raw register values
    task automatic randomize_view();
        int kind;
        kind = $urandom_range(9);
        if (kind == 0) begin
            set_view($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        end else begin
            set_view(int'($urandom_range(3 * Q_ONE)) - 5 * Q_ONE / 2,
                     int'($urandom_range(3 * Q_ONE)) - 3 * Q_ONE / 2,
                     $urandom_range(1 << 19), $urandom_range(1 << 19),
                     (kind == 1) ? 255 : $urandom_range(1, 48));
        end
    endtask

    task automatic test_random_viewports(int send_pct, int recv_pct, int phases);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (phases) begin
            randomize_view();
            repeat (PHASE_PIXELS) begin
                send_at($urandom_range(MAX_DIM - 1), $urandom_range(MAX_DIM - 1));
            end
            release_input();
            wait_drain();
        end
    endtask

    initial begin
        viewport = '{-32'sd536870912, -32'sd268435456, 31'd262144, 31'd262144, 8'd255};
        send_idle_pct = 12;
        recv_idle_pct = 70;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_view();
        test_iteration_limit();
        test_coordinate_saturation();
        test_color_floor();
        test_receiver_hold_off();
        test_random_viewports(12, 70, 14);
        test_random_viewports(70, 12, 14);
        test_random_viewports(0, 0, 14);
        // catch any stray result after the last expected one
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("mandelbrot_escape_time_pixel_tb: clean");
        end else begin
            $display("mandelbrot_escape_time_pixel_tb: errors");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/mbet_pkg.sv
hw/rtl/mbet_core.sv
hw/rtl/mandelbrot_escape_time_pixel.sv
verif/mandelbrot_escape_time_pixel_tb.sv
